[rtl/core/tcptq_pkg.sv]
// ----------------------------------------------------------------------------
// tcptq_pkg
// Shared types and codes for the two-class priority ticket queue.
// ----------------------------------------------------------------------------
package tcptq_pkg;

  localparam int TICKET_W = 7;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;

  typedef logic [TICKET_W-1:0] ticket_t;
  typedef logic [OCC_W-1:0]    occ_t;

  // Action codes
  localparam logic ACT_ENQ = 1'b0;
  localparam logic ACT_DEQ = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

endpackage

[rtl/core/tcptq_if.sv]
// ----------------------------------------------------------------------------
// tcptq channel interfaces
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface tcptq_in_if;
  logic                 valid;
  logic                 ready;
  logic                 action;
  tcptq_pkg::ticket_t   ticket_number;
  logic                 priority_flag;

  modport source (output valid, action, ticket_number, priority_flag, input ready);
  modport sink   (input valid, action, ticket_number, priority_flag, output ready);
endinterface

interface tcptq_out_if;
  logic                 valid;
  logic                 ready;
  tcptq_pkg::status_t   status;
  tcptq_pkg::ticket_t   served_ticket;
  logic                 served_priority;
  tcptq_pkg::occ_t      occupancy;

  modport source (output valid, status, served_ticket, served_priority, occupancy,
                  input ready);
  modport sink   (input valid, status, served_ticket, served_priority, occupancy,
                  output ready);
endinterface

[rtl/core/tcptq_ram.sv]
// ----------------------------------------------------------------------------
// tcptq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tcptq_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/two_class_priority_ticket_queue.sv]
// ----------------------------------------------------------------------------
// two_class_priority_ticket_queue
// Bounded ticket queue with two classes; dequeue serves priority tickets first.
// ----------------------------------------------------------------------------
//
//   channel  | dir | handshake       | payload
//   ---------+-----+-----------------+-----------------------------------------
//   in_if    | in  | valid / ready   | action, ticket_number, priority_flag
//   out_if   | out | valid / ready   | status, served_ticket, served_priority,
//            |     |                 | occupancy
//
// One item per cycle sustained while out_if.ready stays high; each accepted item
// passes through the input register, then the result register.
// The head entries of both class stores are read ahead every cycle from the
// next head pointers, so the registered RAM read lines up with the item in
// the input register; a write to the entry being read is bypassed.
// Reset (rst_n low, synchronous) clears pointers, counts and valid flags; the
// stores are not cleared. A stalled result holds the input register, which
// then holds in_if.ready low.
// ----------------------------------------------------------------------------
module two_class_priority_ticket_queue #(
  parameter int DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  tcptq_in_if.sink             in_if,
  tcptq_out_if.source          out_if
);

  localparam int PW = $clog2(DEPTH);      // pointer width
  localparam int CW = $clog2(DEPTH + 1);  // count width

  // Input register
  logic                a_valid_r;
  logic                a_action_r;
  tcptq_pkg::ticket_t  a_ticket_r;
  logic                a_prio_r;

  // Queue state
  logic [PW-1:0] ph_r, pt_r, nh_r, nt_r;
  logic [PW-1:0] ph_nxt, pt_nxt, nh_nxt, nt_nxt;
  logic [CW-1:0] pc_r, nc_r, pc_nxt, nc_nxt;
  logic [CW-1:0] total, total_nxt;

  // Head read-ahead and bypass
  tcptq_pkg::ticket_t p_rdata, n_rdata, p_head, n_head;
  logic               p_byp_r, n_byp_r;
  tcptq_pkg::ticket_t p_byp_data_r, n_byp_data_r;

  // Result register
  logic                out_valid_r;
  tcptq_pkg::status_t  out_status_r, status_nxt;
  tcptq_pkg::ticket_t  out_ticket_r, ticket_nxt;
  logic                out_prio_r, prio_nxt;
  tcptq_pkg::occ_t     out_occ_r;

  logic in_fire, b_fire;
  logic is_enq, is_full;
  logic p_avail, n_avail;
  logic p_wr, n_wr, p_rd, n_rd;

  // Handshake: advance the input register whenever the result register frees up
  assign b_fire      = a_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !a_valid_r || b_fire;
  assign in_fire     = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_fire) begin
      a_valid_r <= 1'b1;
    end else if (b_fire) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_action_r <= in_if.action;
      a_ticket_r <= in_if.ticket_number;
      a_prio_r   <= in_if.priority_flag;
    end
  end

  // Decode the item in the input register
  assign total   = pc_r + nc_r;
  assign is_enq  = (a_action_r == tcptq_pkg::ACT_ENQ);
  assign is_full = (total == CW'(DEPTH));
  assign p_avail = (pc_r != '0);
  assign n_avail = (nc_r != '0);

  assign p_wr = b_fire && is_enq && !is_full && a_prio_r;
  assign n_wr = b_fire && is_enq && !is_full && !a_prio_r;
  assign p_rd = b_fire && !is_enq && p_avail;
  assign n_rd = b_fire && !is_enq && !p_avail && n_avail;

  // Pointer wrap at DEPTH
  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] ptr);
    wrap_inc = (ptr == PW'(DEPTH - 1)) ? '0 : ptr + PW'(1);
  endfunction

  always_comb begin
    ph_nxt = p_rd ? wrap_inc(ph_r) : ph_r;
    pt_nxt = p_wr ? wrap_inc(pt_r) : pt_r;
    nh_nxt = n_rd ? wrap_inc(nh_r) : nh_r;
    nt_nxt = n_wr ? wrap_inc(nt_r) : nt_r;
    pc_nxt = pc_r;
    nc_nxt = nc_r;
    if (p_wr) begin
      pc_nxt = pc_r + CW'(1);
    end else if (p_rd) begin
      pc_nxt = pc_r - CW'(1);
    end
    if (n_wr) begin
      nc_nxt = nc_r + CW'(1);
    end else if (n_rd) begin
      nc_nxt = nc_r - CW'(1);
    end
    total_nxt = pc_nxt + nc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= '0;
      pt_r <= '0;
      nh_r <= '0;
      nt_r <= '0;
      pc_r <= '0;
      nc_r <= '0;
    end else begin
      ph_r <= ph_nxt;
      pt_r <= pt_nxt;
      nh_r <= nh_nxt;
      nt_r <= nt_nxt;
      pc_r <= pc_nxt;
      nc_r <= nc_nxt;
    end
  end

  // Class stores: write at tail, read ahead at the next head
  tcptq_ram #(.WIDTH(tcptq_pkg::TICKET_W), .DEPTH(DEPTH)) u_prio_ram (
    .clk   (clk),
    .we    (p_wr),
    .waddr (pt_r),
    .wdata (a_ticket_r),
    .raddr (ph_nxt),
    .rdata (p_rdata)
  );

  tcptq_ram #(.WIDTH(tcptq_pkg::TICKET_W), .DEPTH(DEPTH)) u_norm_ram (
    .clk   (clk),
    .we    (n_wr),
    .waddr (nt_r),
    .wdata (a_ticket_r),
    .raddr (nh_nxt),
    .rdata (n_rdata)
  );

  // The RAM returns old data when the head entry is written in the same
  // cycle (empty class); register the new ticket and select it instead.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_byp_r <= 1'b0;
      n_byp_r <= 1'b0;
    end else begin
      p_byp_r <= p_wr && (pt_r == ph_nxt);
      n_byp_r <= n_wr && (nt_r == nh_nxt);
    end
  end

  always_ff @(posedge clk) begin
    p_byp_data_r <= a_ticket_r;
    n_byp_data_r <= a_ticket_r;
  end

  assign p_head = p_byp_r ? p_byp_data_r : p_rdata;
  assign n_head = n_byp_r ? n_byp_data_r : n_rdata;

  // Result fields
  always_comb begin
    status_nxt = tcptq_pkg::ST_DONE;
    ticket_nxt = '0;
    prio_nxt   = 1'b0;
    if (is_enq) begin
      if (is_full) begin
        status_nxt = tcptq_pkg::ST_FULL;
      end
    end else if (p_avail) begin
      ticket_nxt = p_head;
      prio_nxt   = 1'b1;
    end else if (n_avail) begin
      ticket_nxt = n_head;
    end else begin
      status_nxt = tcptq_pkg::ST_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (b_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire) begin
      out_status_r <= status_nxt;
      out_ticket_r <= ticket_nxt;
      out_prio_r   <= prio_nxt;
      out_occ_r    <= tcptq_pkg::occ_t'(total_nxt);
    end
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.status          = out_status_r;
  assign out_if.served_ticket   = out_ticket_r;
  assign out_if.served_priority = out_prio_r;
  assign out_if.occupancy       = out_occ_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ((CW+1)'(pc_r) + (CW+1)'(nc_r)) <= (CW+1)'(DEPTH))
    else $error("ticket count exceeds depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    ((pc_r == '0) |-> (ph_r == pt_r)) and ((nc_r == '0) |-> (nh_r == nt_r)))
    else $error("empty class with head and tail apart");

  a_prio_first: assert property (@(posedge clk) disable iff (!rst_n)
    (b_fire && !is_enq && p_avail) |=> (out_valid_r && out_prio_r))
    else $error("dequeue skipped a waiting priority ticket");

  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == tcptq_pkg::ST_EMPTY) |-> (out_occ_r == '0))
    else $error("empty status with nonzero occupancy");

endmodule
